// File: src/sha256_byte_stream_hasher_top_macros.svh
// Assertion helpers for the hasher
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH

`define SBH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define SBH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sbh_pkg.sv
`default_nettype none
package sbh_pkg;

  localparam int LenBitsDefault = 64;

  typedef logic [31:0] word_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// File: src/sha256_byte_stream_hasher_top.sv
// A byte that does not fill a block is only stored; a byte that fills one starts a
// compression: load, 64 rounds of the shared round unit, and chain update.
// End of message: padding runs one compression, or two when the length spills into a second
// block, then eight output transfers, one per cycle when out_tready is high.
// in_tready is high only in idle, so no byte is taken while a block is padded, compressed or output.
// Reset: synchronous active-low rst_n reloads the initial hash and clears the bit count.
`default_nettype none
module sha256_byte_stream_hasher_top
  import sbh_pkg::*;
#(
  parameter int LENGTH_COUNTER_BITS = LenBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // byte_present
  input  wire logic        in_tlast,   // end_of_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] digest_word, [34:32] word_index, zero
  output logic             out_tlast   // last_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam int LB = LENGTH_COUNTER_BITS;

  logic [2:0]    state_r, state_nxt;
  word_t         w_r [16];
  word_t         h_r [8];
  word_t         v_r [8];
  logic [LB-1:0] cnt_r;
  logic [63:0]   len_r;
  logic [6:0]    rnd_r;
  logic          fin_r;   // message ends after this compression
  logic          more_r;  // a second padding block follows
  logic          pend_r;  // padding still due after this compression
  logic [2:0]    oidx_r;

  logic [5:0]  pos;
  logic        acc;
  logic [3:0]  wi;
  logic [63:0] cnt64;
  word_t       w15, w2, w7, wnew, wt, t1, t2, s0, s1, s0a, s1a, ch, mj;

  assign pos = cnt_r[8:3];
  assign cnt64 = 64'(cnt_r);
  assign acc = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign wi = rnd_r[3:0];

  always_comb begin
    w15  = w_r[4'(wi + 4'd1)];
    w2   = w_r[4'(wi + 4'd14)];
    w7   = w_r[4'(wi + 4'd9)];
    s0   = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    s1   = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    wnew = w_r[wi] + s0 + w7 + s1;
    wt   = rnd_r[6:4] != 3'd0 ? wnew : w_r[wi];
    s1a  = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + s1a + ch + RoundK[rnd_r[5:0]] + wt;
    s0a  = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    mj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2   = s0a + mj;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_tuser && pos == 6'd63) begin
            state_nxt = S_RND;
          end else if (in_tlast) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: state_nxt = S_RND;
      S_RND: if (rnd_r == 7'd63) state_nxt = S_ADD;
      S_ADD: begin
        if (more_r) begin
          state_nxt = S_RND;
        end else if (fin_r) begin
          state_nxt = S_OUT;
        end else if (pend_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: if (out_tready && oidx_r == 3'd7) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rnd_r   <= '0;
      fin_r   <= 1'b0;
      more_r  <= 1'b0;
      pend_r  <= 1'b0;
      oidx_r  <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= InitHash[i];
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          rnd_r <= '0;
          if (acc) begin
            fin_r  <= 1'b0;
            pend_r <= in_tlast;
            more_r <= 1'b0;
            if (in_tuser) begin
              w_r[pos[5:2]][8'(3 - pos[1:0]) * 8 +: 8] <= in_tdata;
              cnt_r <= cnt_r + LB'(8);
            end
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          end
        end
        S_PAD: begin
          // place 0x80, zero the tail, append the length if it fits
          len_r <= cnt64;
          for (int j = 0; j < 64; j++) begin
            if (j == pos) begin
              w_r[j/4][(3 - j%4)*8 +: 8] <= 8'h80;
            end else if (j > pos) begin
              if (pos < 6'd56 && j >= 56) w_r[j/4][(3 - j%4)*8 +: 8] <= cnt64[(63 - j)*8 +: 8];
              else w_r[j/4][(3 - j%4)*8 +: 8] <= 8'h00;
            end
          end
          if (pos >= 6'd56) more_r <= 1'b1;
          fin_r  <= 1'b1;
          pend_r <= 1'b0;
        end
        S_RND: begin
          if (rnd_r[6:4] != 3'd0) w_r[wi] <= wnew;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r  <= rnd_r + 7'd1;
        end
        S_ADD: begin
          rnd_r <= '0;
          for (int i = 0; i < 8; i++) begin
            h_r[i] <= h_r[i] + v_r[i];
            v_r[i] <= h_r[i] + v_r[i];
          end
          if (more_r) begin
            more_r <= 1'b0;
            for (int i = 0; i < 14; i++) w_r[i] <= '0;
            w_r[14] <= len_r[63:32];
            w_r[15] <= len_r[31:0];
          end
          oidx_r <= '0;
          if (fin_r && !more_r) cnt_r <= '0;
        end
        S_OUT: begin
          if (out_tready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= InitHash[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {5'd0, oidx_r, h_r[oidx_r]};
  assign out_tlast  = (oidx_r == 3'd7);

  `include "sha256_byte_stream_hasher_top_macros.svh"

  `SBH_ASSERT_IMP(a_rdy_idle, in_tready, (state_r == S_IDLE), "ready outside idle")
  `SBH_ASSERT_NXT(a_out_done, (out_tvalid && out_tready && out_tlast), (state_r == S_IDLE), "no idle after digest")
  `SBH_ASSERT_IMP(a_rnd_rng, (state_r == S_RND), (rnd_r < 7'd64), "round out of range")

endmodule
`default_nettype wire
